FILE: rtl/pcb_pkg.sv
// Shared types and constants for the particle cell binning core.
`timescale 1ns / 1ps
package pcb_pkg;

    // Payload widths
    localparam int ID_W     = 16;
    localparam int POS_W    = 32;
    localparam int CPD_W    = 5;
    localparam int INV_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CIDX_W   = 12;
    localparam int SLOT_W   = 4;
    localparam int FILL_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPD = 1'b0,
        CFG_INV = 1'b1
    } t_cfg_idx;

    localparam logic [CPD_W-1:0] CPD_RESET = 5'd8;
    localparam logic [INV_W-1:0] INV_RESET = 32'd65536;

    // Parameter defaults
    localparam int MAX_CELLS_PER_DIR_DEF = 16;
    localparam int SLOTS_PER_CELL_DEF    = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

FILE: rtl/particle_cell_binning_core.sv
// Particle cell binning core: iterative cell index with one shared multiplier.
// Each request steps through S_MULX, S_MULY, S_MULZ, S_CHKZ, S_IDX1, S_IDX2, S_READ
//   and S_DONE; a new request is taken only in S_IDLE, as the shared 32x32 multiplier
//   (three position scalings, two index products) and the fill-count read serve one
//   request at a time. Reset: synchronous, active low; afterwards a clearing pass
//   zeroes the fill counts of all MAX_CELLS_PER_DIR**3 cells (4096 by default), one cell a cycle.
`timescale 1ns / 1ps
module particle_cell_binning_core #(
    parameter int MAX_CELLS_PER_DIR = pcb_pkg::MAX_CELLS_PER_DIR_DEF,
    parameter int SLOTS_PER_CELL    = pcb_pkg::SLOTS_PER_CELL_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // particle in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pcb_pkg::ID_W-1:0]        i_particle_id,
    input  logic signed [pcb_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pcb_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [pcb_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [pcb_pkg::POS_W-1:0] i_charge,
    // result out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pcb_pkg::STATUS_W-1:0]    o_status,
    output logic [pcb_pkg::CIDX_W-1:0]      o_cell_index,
    output logic [pcb_pkg::SLOT_W-1:0]      o_slot,
    output logic [pcb_pkg::FILL_W-1:0]      o_cell_fill
);
    import pcb_pkg::*;

    localparam int NUM_CELLS = MAX_CELLS_PER_DIR * MAX_CELLS_PER_DIR * MAX_CELLS_PER_DIR;
    localparam int CIW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CCW = (MAX_CELLS_PER_DIR > 1) ? $clog2(MAX_CELLS_PER_DIR) : 1;
    localparam int CPW = $clog2(MAX_CELLS_PER_DIR + 1);
    localparam int SW  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int FW  = $clog2(SLOTS_PER_CELL + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_MULZ,
        S_CHKZ,
        S_IDX1,
        S_IDX2,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
        logic [POS_W-1:0] q;
    } t_slot;

    t_state r_state;
    logic [CPD_W-1:0]  r_cpd_cfg;
    logic [INV_W-1:0]  r_inv;
    logic              r_clr_busy;
    logic [CIW-1:0]    r_clr_addr;

    logic [ID_W-1:0]   r_id;
    logic [POS_W-1:0]  r_px, r_py, r_pz, r_q;
    logic [2*POS_W-1:0] r_prod;
    logic              r_bad;
    logic [CCW-1:0]    r_cx, r_cy, r_cz;
    logic [CIW-1:0]    r_idx;
    logic [FW-1:0]     r_cnt_rd;

    logic [FW-1:0]     r_cnt_mem  [NUM_CELLS];
    t_slot             r_slot_mem [NUM_CELLS][SLOTS_PER_CELL];

    logic [CPW-1:0]    cpd_eff;
    logic [POS_W-1:0]  mul_a, mul_b;
    logic [2*POS_W-1:0] mul_p;
    logic              axis_bad;
    logic              in_fire, done_fire, is_full, do_store;
    logic              cnt_we;
    logic [CIW-1:0]    cnt_waddr;
    logic [FW-1:0]     cnt_wdata, fill_next;

    function automatic logic [POS_W-1:0] mag(input logic [POS_W-1:0] v);
        mag = v[POS_W-1] ? (~v + 1'b1) : v;
    endfunction

    // saturate the programmed cell count
    always_comb begin
        if (32'(r_cpd_cfg) > 32'(MAX_CELLS_PER_DIR)) begin
            cpd_eff = CPW'(MAX_CELLS_PER_DIR);
        end else begin
            cpd_eff = CPW'(r_cpd_cfg);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MULX: begin mul_a = mag(r_px); mul_b = r_inv; end
            S_MULY: begin mul_a = mag(r_py); mul_b = r_inv; end
            S_MULZ: begin mul_a = mag(r_pz); mul_b = r_inv; end
            S_CHKZ: begin mul_a = 32'(cpd_eff); mul_b = 32'(r_cx); end
            S_IDX1: begin
                mul_a = 32'(r_prod[CIW-1:0] + CIW'(r_cy));
                mul_b = 32'(cpd_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // range check on the product left by the previous step
    logic axis_neg;
    always_comb begin
        case (r_state)
            S_MULY:  axis_neg = r_px[POS_W-1];
            S_MULZ:  axis_neg = r_py[POS_W-1];
            default: axis_neg = r_pz[POS_W-1];
        endcase
        if (axis_neg) begin
            axis_bad = (r_prod != '0);
        end else begin
            axis_bad = (r_prod[2*POS_W-1:POS_W] >= 32'(cpd_eff));
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || r_clr_busy;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign done_fire  = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);
    assign is_full    = (r_cnt_rd >= FW'(SLOTS_PER_CELL));
    assign do_store   = done_fire && !r_bad && !is_full;
    assign fill_next  = r_cnt_rd + 1'b1;

    assign cnt_we    = r_clr_busy || do_store;
    assign cnt_waddr = r_clr_busy ? r_clr_addr : r_idx;
    assign cnt_wdata = r_clr_busy ? '0 : fill_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpd_cfg   <= CPD_RESET;
            r_inv       <= INV_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CPD: r_cpd_cfg <= i_cfg_data[CPD_W-1:0];
                    CFG_INV: r_inv     <= i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == 32'(NUM_CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (done_fire) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_id    <= i_particle_id;
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_pz    <= i_pos_z;
                        r_q     <= i_charge;
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_prod  <= mul_p;
                    r_bad   <= 1'b0;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_bad   <= axis_bad;
                    r_cx    <= r_prod[POS_W +: CCW];
                    r_prod  <= mul_p;
                    r_state <= S_MULZ;
                end
                S_MULZ: begin
                    r_bad   <= r_bad | axis_bad;
                    r_cy    <= r_prod[POS_W +: CCW];
                    r_prod  <= mul_p;
                    r_state <= S_CHKZ;
                end
                S_CHKZ: begin
                    r_bad   <= r_bad | axis_bad;
                    r_cz    <= r_prod[POS_W +: CCW];
                    r_prod  <= mul_p;            // cpd * cx
                    r_state <= S_IDX1;
                end
                S_IDX1: begin
                    r_prod  <= mul_p;            // (cpd * cx + cy) * cpd
                    r_state <= S_IDX2;
                end
                S_IDX2: begin
                    r_idx   <= r_prod[CIW-1:0] + CIW'(r_cz);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_DONE;           // count read in flight
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_state     <= S_IDLE;
                        if (r_bad) begin
                            o_status     <= ST_OUTSIDE;
                            o_cell_index <= '0;
                            o_slot       <= '0;
                            o_cell_fill  <= '0;
                        end else if (is_full) begin
                            o_status     <= ST_FULL;
                            o_cell_index <= CIDX_W'(r_idx);
                            o_slot       <= '0;
                            o_cell_fill  <= FILL_W'(r_cnt_rd);
                        end else begin
                            o_status     <= ST_STORED;
                            o_cell_index <= CIDX_W'(r_idx);
                            o_slot       <= SLOT_W'(r_cnt_rd);
                            o_cell_fill  <= FILL_W'(fill_next);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // fill counts: one write port (clear or update), registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (r_state == S_READ) begin
            r_cnt_rd <= r_cnt_mem[r_idx];
        end
    end

    // particle slot store
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_slot_mem[r_idx][r_cnt_rd[SW-1:0]] <= '{
                id: r_id, px: r_px, py: r_py, pz: r_pz, q: r_q
            };
        end
    end

endmodule

FILE: rtl/pcb_checker.sv
// Port-level checker for the particle cell binning core, with its bind.
`timescale 1ns / 1ps
module pcb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [pcb_pkg::STATUS_W-1:0] o_status,
    input logic [pcb_pkg::CIDX_W-1:0]   o_cell_index,
    input logic [pcb_pkg::SLOT_W-1:0]   o_slot,
    input logic [pcb_pkg::FILL_W-1:0]   o_cell_fill
);
    import pcb_pkg::*;

    logic [FILL_W-1:0] fill_less_one;
    assign fill_less_one = o_cell_fill - 1'b1;

    // a taken request keeps the block busy for its whole iteration
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again in the cycle after a request");

    // dropped outside the box: all index fields zero
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OUTSIDE) |->
            (o_cell_index == '0 && o_slot == '0 && o_cell_fill == '0))
        else $error("outside-box result carries non-zero fields");

    // stored: fill after the step is one past the slot used
    a_stored_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_STORED) |->
            (fill_less_one[SLOT_W-1:0] == o_slot))
        else $error("stored result fill does not follow slot");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_cell_index)
             && $stable(o_slot) && $stable(o_cell_fill)))
        else $error("stalled result changed");

endmodule

bind particle_cell_binning_core pcb_checker u_pcb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_cell_index (o_cell_index),
    .o_slot       (o_slot),
    .o_cell_fill  (o_cell_fill)
);

FILE: bench/testbench.sv
// Self-checking testbench for the particle cell binning core.
`timescale 1ns / 1ps
module testbench;
    import pcb_pkg::*;

    localparam int MAX_CPD      = MAX_CELLS_PER_DIR_DEF;
    localparam int SLOTS        = SLOTS_PER_CELL_DEF;
    localparam int NUM_BINS     = MAX_CPD * MAX_CPD * MAX_CPD;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [POS_W-1:0] charge;
    } t_particle;

    typedef struct packed {
        t_status           status;
        logic [CIDX_W-1:0] cell_idx;
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] fill;
    } t_bin_result;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [ID_W-1:0]         i_particle_id = '0;
    logic signed [POS_W-1:0] i_pos_x       = '0;
    logic signed [POS_W-1:0] i_pos_y       = '0;
    logic signed [POS_W-1:0] i_pos_z       = '0;
    logic signed [POS_W-1:0] i_charge      = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic [CIDX_W-1:0]       o_cell_index;
    logic [SLOT_W-1:0]       o_slot;
    logic [FILL_W-1:0]       o_cell_fill;

    particle_cell_binning_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: register copies and per-cell fill counts
    logic [CPD_W-1:0]  cfg_cpd = CPD_RESET;
    logic [INV_W-1:0]  cfg_inv = INV_RESET;
    logic [FILL_W-1:0] bin_fill [NUM_BINS];

    t_bin_result expected_bins [$];

    int mismatches       = 0;
    int results_checked  = 0;
    int n_sent           = 0;
    int n_stored         = 0;
    int n_outside        = 0;
    int n_full           = 0;
    int n_settings       = 0;
    int sink_hold_cycles = 0;
    bit sender_idles     = 1'b1;
    bit sink_idles       = 1'b1;

    // Floor of the Q32.32 product; a negative position survives only if it scales to zero
    function automatic bit axis_cell(logic [POS_W-1:0] p, int unsigned cells,
                                     output int unsigned c);
        logic [POS_W-1:0] mag;
        logic [63:0]      prod;
        mag  = p[POS_W-1] ? (~p + 1'b1) : p;
        prod = {32'd0, mag} * {32'd0, cfg_inv};
        if (p[POS_W-1]) begin
            c = 0;
            return prod == 64'd0;
        end
        c = prod[63:32];
        return prod[63:32] < cells;
    endfunction

    function automatic t_bin_result bin_particle(t_particle p);
        t_bin_result       r;
        int unsigned       cells, cx, cy, cz, idx;
        bit                ok;
        logic [FILL_W-1:0] fill;
        cells = (cfg_cpd > MAX_CPD) ? MAX_CPD : cfg_cpd;
        r.status   = ST_OUTSIDE;
        r.cell_idx = '0;
        r.slot     = '0;
        r.fill     = '0;
        ok = axis_cell(p.pos_x, cells, cx);
        ok = axis_cell(p.pos_y, cells, cy) && ok;
        ok = axis_cell(p.pos_z, cells, cz) && ok;
        if (!ok) begin
            n_outside++;
            return r;
        end
        idx        = cells * cells * cx + cells * cy + cz;
        fill       = bin_fill[idx];
        r.cell_idx = idx[CIDX_W-1:0];
        r.fill     = fill;
        if (fill >= SLOTS) begin
            r.status = ST_FULL;
            n_full++;
            return r;
        end
        bin_fill[idx] = fill + 1'b1;
        r.status = ST_STORED;
        r.slot   = fill[SLOT_W-1:0];
        r.fill   = fill + 1'b1;
        n_stored++;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_bin_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected result, cell_index", o_cell_index, -1);
            end else begin
                want = expected_bins.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_cell_index !== want.cell_idx)
                    report_mismatch("cell_index", o_cell_index, want.cell_idx);
                if (o_slot !== want.slot)
                    report_mismatch("slot", o_slot, want.slot);
                if (o_cell_fill !== want.fill)
                    report_mismatch("cell_fill", o_cell_fill, want.fill);
            end
        end
    end

    // Result side: long hold-off on demand, random stall bursts, open stretches
    initial begin : sink_driver
        int n;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
                sink_hold_cycles = 0;
            end else if (sink_idles && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    task automatic send_particle(t_particle p);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_particle_id <= p.id;
        i_pos_x       <= p.pos_x;
        i_pos_y       <= p.pos_y;
        i_pos_z       <= p.pos_z;
        i_charge      <= p.charge;
        do @(posedge i_clk); while (o_in_stall);
        expected_bins.push_back(bin_particle(p));
        n_sent++;
    endtask

    task automatic maybe_pause_sender();
        int n;
        if (!sender_idles || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 6);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_CPD)
            cfg_cpd = value[CPD_W-1:0];
        else
            cfg_inv = value;
    endtask

    task automatic set_binning(logic [CFG_DATA_W-1:0] cpd, logic [CFG_DATA_W-1:0] inv);
        wait_results_drained();
        write_reg(CFG_CPD, cpd);
        write_reg(CFG_INV, inv);
        n_settings++;
    endtask

    // Mostly inside a unit box, some just outside, some fully random or at the corners
    function automatic logic [POS_W-1:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 65535);
        if (roll < 88)
            return roll[0] ? 32'd65536 + $urandom_range(0, 4095) : 32'd0 - $urandom_range(1, 65535);
        if (roll < 95)
            return $urandom();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_FFFF;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_particle rand_particle();
        t_particle p;
        p.id     = $urandom_range(0, 65535);
        p.pos_x  = pick_coord();
        p.pos_y  = pick_coord();
        p.pos_z  = pick_coord();
        p.charge = $urandom();
        return p;
    endfunction

    // Reset register values, then zero cells, saturation, wide and zero reciprocal
    task automatic test_directed();
        send_particle('{16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_particle('{16'hFFFF, 32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, 32'h7FFF_FFFF});
        send_particle('{16'h1234, 32'h0008_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001});
        send_particle('{16'h4321, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
        send_particle('{16'h00FF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000});
        send_particle('{16'hFF00, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_particle('{16'h0001, 32'h0001_0000, 32'h0002_8000, 32'h0003_0000, 32'h8000_0000});
        send_particle('{16'h0002, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        set_binning(0, 32'h0001_0000);
        send_particle('{16'h0003, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        // above the maximum the cell count saturates
        set_binning(31, 32'hFFFF_FFFF);
        send_particle('{16'h0004, 32'd16, 32'd16, 32'd16, 32'h0000_0000});
        send_particle('{16'h0005, 32'd17, 32'd0, 32'd0, 32'h0000_0000});
        send_particle('{16'h0006, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h0000_0000});
        // zero reciprocal width: everything, negatives too, lands in cell 0
        set_binning(4, 32'h0000_0000);
        send_particle('{16'h0007, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});
        send_particle(rand_particle());
        wait_results_drained();
    endtask

    task automatic test_cell_full();
        int n;
        set_binning(1, 32'h0000_0000);
        n = SLOTS - bin_fill[0] + 2;
        repeat (n) send_particle(rand_particle());
        wait_results_drained();
    endtask

    // Receiver holds off while requests keep coming, so the input side stalls
    task automatic test_backpressure();
        set_binning(16, 32'h0010_0000);
        sink_hold_cycles = HOLD_CYCLES;
        repeat (16) send_particle(rand_particle());
        wait_results_drained();
    endtask

    task automatic test_random_binning();
        int unsigned phase_cpd [8] = '{2, 16, 5, 31, 1, 3, 9, 12};
        int unsigned cells;
        foreach (phase_cpd[ph]) begin
            cells = (phase_cpd[ph] > MAX_CPD) ? MAX_CPD : phase_cpd[ph];
            set_binning(phase_cpd[ph], cells << 16);
            if (ph == 7) begin
                sender_idles = 1'b0;
                sink_idles   = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // now and then the sender waits for every outstanding result
                if (i % 40 == 39 && sender_idles)
                    wait_results_drained();
                else
                    maybe_pause_sender();
                send_particle(rand_particle());
            end
        end
        wait_results_drained();
    endtask

    initial begin : run_tests
        foreach (bin_fill[i])
            bin_fill[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_cell_full();
        test_backpressure();
        test_random_binning();

        wait_results_drained();
        $display("Binned %0d particles under %0d register settings after reset values",
                 n_sent, n_settings);
        $display("Outcomes: %0d stored, %0d outside box, %0d cell full; %0d results checked",
                 n_stored, n_outside, n_full, results_checked);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
